// ===== sv/hkrb_pkg.sv =====
`timescale 1ns / 1ps

package hkrb_pkg;

  // Number of key slots kept in the keyboard report.
  localparam int KEY_SLOT_COUNT = 6;
  localparam int SLOT_IDX_W = (KEY_SLOT_COUNT > 1) ? $clog2(KEY_SLOT_COUNT) : 1;

  // Number of slot fields shown in a result.
  localparam int SHOWN_SLOTS = 6;

  typedef enum logic [2:0] {
    FUNC_KEY_PRESS   = 3'd0,
    FUNC_KEY_RELEASE = 3'd1,
    FUNC_MEDIA_PRESS = 3'd2,
    FUNC_MEDIA_REL   = 3'd3,
    FUNC_RELEASE_ALL = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_SENT      = 2'd0,
    ST_WRITE_ERR = 2'd1,
    ST_UNMAPPED  = 2'd2
  } status_t;

  localparam logic [0:0] KIND_KEYBOARD = 1'b0;
  localparam logic [0:0] KIND_MEDIA    = 1'b1;

  localparam logic [7:0] CODE_RAW_BASE = 8'd136;
  localparam logic [7:0] USAGE_SHIFT_FLAG = 8'h80;
  localparam logic [7:0] USAGE_MASK = 8'h7F;
  localparam logic [7:0] LEFT_SHIFT_BIT = 8'h02;

  typedef logic [7:0] slot_array_t [KEY_SLOT_COUNT];

  // ASCII to usage; bit 7 of an entry means left shift is held too.
  localparam logic [7:0] ASCII_USAGE [128] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2a,8'h2b,8'h28,8'h00,8'h00,8'h28,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h2c,8'h9e,8'hb4,8'ha0,8'ha1,8'ha2,8'ha4,8'h34,8'ha6,8'ha7,8'ha5,8'hae,8'h36,8'h2d,8'h37,8'h38,
    8'h27,8'h1e,8'h1f,8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'hb3,8'h33,8'hb6,8'h2e,8'hb7,8'hb8,
    8'h9f,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,8'h90,8'h91,8'h92,
    8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'h9b,8'h9c,8'h9d,8'h2f,8'h31,8'h30,8'ha3,8'had,
    8'h35,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,8'h10,8'h11,8'h12,
    8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1a,8'h1b,8'h1c,8'h1d,8'haf,8'hb1,8'hb0,8'hb5,8'h00
  };

endpackage

// ===== sv/hkrb_in_if.sv =====
`timescale 1ns / 1ps

interface hkrb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  key_code;
  logic [15:0] media_bits;

  modport source (output valid, output func, output key_code, output media_bits, input ready);
  modport sink (input valid, input func, input key_code, input media_bits, output ready);
endinterface

// ===== sv/hkrb_out_if.sv =====
`timescale 1ns / 1ps

interface hkrb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        report_kind;
  logic [7:0]  modifier_bits;
  logic [7:0]  slot_zero;
  logic [7:0]  slot_one;
  logic [7:0]  slot_two;
  logic [7:0]  slot_three;
  logic [7:0]  slot_four;
  logic [7:0]  slot_five;
  logic [15:0] media_report;

  modport source (
    output valid, output status, output report_kind, output modifier_bits,
    output slot_zero, output slot_one, output slot_two, output slot_three,
    output slot_four, output slot_five, output media_report, input ready
  );
  modport sink (
    input valid, input status, input report_kind, input modifier_bits,
    input slot_zero, input slot_one, input slot_two, input slot_three,
    input slot_four, input slot_five, input media_report, output ready
  );
endinterface

// ===== sv/hid_key_report_builder_core.sv =====
`timescale 1ns / 1ps
// An accepted request waits in the input register, then moves to the result
// register once the output is free. Throughput: one request per cycle while
// reports are taken, set by the single slot search and update pass between them.
// Requests with an unknown function code are dropped and give no report.
// Reset (rst, synchronous) empties both registers and clears the modifier
// byte, all key slots and the media bitmap.
module hid_key_report_builder_core (
  input  logic       clk,
  input  logic       rst,
  hkrb_in_if.sink    events,
  hkrb_out_if.source reports
);

  // Input register
  logic        in_valid;
  logic [2:0]  in_func;
  logic [7:0]  in_code;
  logic [15:0] in_bits;

  // Report state
  logic [7:0]           modifier;
  hkrb_pkg::slot_array_t slots;
  logic [15:0]          media;

  logic [7:0]           modifier_next;
  hkrb_pkg::slot_array_t slots_next;
  logic [15:0]          media_next;
  logic [1:0]           status_next;
  logic                 kind_next;
  logic                 known_func;

  // Result register
  logic        out_valid;
  logic [1:0]  out_status;
  logic        out_kind;
  logic [7:0]  out_modifier;
  logic [7:0]  out_slots [hkrb_pkg::SHOWN_SLOTS];
  logic [15:0] out_media;

  logic advance;
  logic out_free;

  logic [7:0] lut;
  logic [7:0] usage;
  logic [7:0] mod_mask;
  logic       unmapped;
  logic       present;
  logic       free_found;
  logic [hkrb_pkg::SLOT_IDX_W-1:0] free_idx;

  assign out_free = !out_valid || reports.ready;
  assign known_func = (in_func == hkrb_pkg::FUNC_KEY_PRESS) ||
                      (in_func == hkrb_pkg::FUNC_KEY_RELEASE) ||
                      (in_func == hkrb_pkg::FUNC_MEDIA_PRESS) ||
                      (in_func == hkrb_pkg::FUNC_MEDIA_REL) ||
                      (in_func == hkrb_pkg::FUNC_RELEASE_ALL);
  // A request with an unknown function leaves without waiting for the output.
  assign advance = in_valid && (out_free || !known_func);
  assign events.ready = !in_valid || advance;

  // Decode the key code into a usage and the modifier bits it touches.
  always_comb begin
    lut = hkrb_pkg::ASCII_USAGE[in_code[6:0]];
    usage = 8'd0;
    mod_mask = 8'd0;
    unmapped = 1'b0;
    if (in_code >= hkrb_pkg::CODE_RAW_BASE) begin
      usage = 8'(in_code - hkrb_pkg::CODE_RAW_BASE);
    end else if (in_code[7]) begin
      mod_mask = 8'(8'd1 << in_code[2:0]);
    end else if (lut == 8'd0) begin
      unmapped = 1'b1;
    end else begin
      if ((lut & hkrb_pkg::USAGE_SHIFT_FLAG) != 8'd0) begin
        mod_mask = hkrb_pkg::LEFT_SHIFT_BIT;
      end
      usage = lut & hkrb_pkg::USAGE_MASK;
    end
  end

  // Look for the usage among the slots and find the first empty one.
  always_comb begin
    present = 1'b0;
    free_found = 1'b0;
    free_idx = '0;
    for (int i = hkrb_pkg::KEY_SLOT_COUNT - 1; i >= 0; i--) begin
      if (slots[i] == usage) begin
        present = 1'b1;
      end
      if (slots[i] == 8'd0) begin
        free_found = 1'b1;
        free_idx = hkrb_pkg::SLOT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    modifier_next = modifier;
    slots_next = slots;
    media_next = media;
    status_next = hkrb_pkg::ST_SENT;
    kind_next = hkrb_pkg::KIND_KEYBOARD;
    case (in_func)
      hkrb_pkg::FUNC_KEY_PRESS: begin
        if (unmapped) begin
          status_next = hkrb_pkg::ST_WRITE_ERR;
        end else begin
          // The modifier bit stays set even when no slot is free.
          modifier_next = modifier | mod_mask;
          if (!present) begin
            if (free_found) begin
              slots_next[free_idx] = usage;
            end else begin
              status_next = hkrb_pkg::ST_WRITE_ERR;
            end
          end
        end
      end
      hkrb_pkg::FUNC_KEY_RELEASE: begin
        if (unmapped) begin
          status_next = hkrb_pkg::ST_UNMAPPED;
        end else begin
          modifier_next = modifier & ~mod_mask;
          for (int i = 0; i < hkrb_pkg::KEY_SLOT_COUNT; i++) begin
            if (usage != 8'd0 && slots[i] == usage) begin
              slots_next[i] = 8'd0;
            end
          end
        end
      end
      hkrb_pkg::FUNC_MEDIA_PRESS: begin
        media_next = media | in_bits;
        kind_next = hkrb_pkg::KIND_MEDIA;
      end
      hkrb_pkg::FUNC_MEDIA_REL: begin
        media_next = media & ~in_bits;
        kind_next = hkrb_pkg::KIND_MEDIA;
      end
      hkrb_pkg::FUNC_RELEASE_ALL: begin
        modifier_next = 8'd0;
        media_next = 16'd0;
        for (int i = 0; i < hkrb_pkg::KEY_SLOT_COUNT; i++) begin
          slots_next[i] = 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (events.ready) begin
      in_valid <= events.valid;
    end
    if (events.valid && events.ready) begin
      in_func <= events.func;
      in_code <= events.key_code;
      in_bits <= events.media_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modifier <= 8'd0;
      media <= 16'd0;
      for (int i = 0; i < hkrb_pkg::KEY_SLOT_COUNT; i++) begin
        slots[i] <= 8'd0;
      end
    end else if (advance && known_func) begin
      modifier <= modifier_next;
      media <= media_next;
      slots <= slots_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && known_func) begin
      out_valid <= 1'b1;
    end else if (reports.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && known_func) begin
      out_status <= status_next;
      out_kind <= kind_next;
      out_modifier <= modifier_next;
      out_media <= media_next;
      for (int i = 0; i < hkrb_pkg::SHOWN_SLOTS; i++) begin
        if (i < hkrb_pkg::KEY_SLOT_COUNT) begin
          out_slots[i] <= slots_next[i];
        end else begin
          out_slots[i] <= 8'd0;
        end
      end
    end
  end

  assign reports.valid = out_valid;
  assign reports.status = out_status;
  assign reports.report_kind = out_kind;
  assign reports.modifier_bits = out_modifier;
  assign reports.slot_zero = out_slots[0];
  assign reports.slot_one = out_slots[1];
  assign reports.slot_two = out_slots[2];
  assign reports.slot_three = out_slots[3];
  assign reports.slot_four = out_slots[4];
  assign reports.slot_five = out_slots[5];
  assign reports.media_report = out_media;

`ifndef SYNTHESIS
  // A media report is only ever sent with a clean status.
  a_kind_status: assert property (@(posedge clk) disable iff (rst)
    (reports.valid && reports.report_kind == hkrb_pkg::KIND_MEDIA) |->
      (reports.status == hkrb_pkg::ST_SENT))
    else $error("media report carries an error status");

  // Release-all leaves the modifier byte and the media bitmap clear.
  a_release_all: assert property (@(posedge clk) disable iff (rst)
    (advance && in_func == hkrb_pkg::FUNC_RELEASE_ALL) |=>
      (modifier == 8'd0 && media == 16'd0))
    else $error("release-all left state behind");

  // An unknown function never produces a report.
  a_unknown_drop: assert property (@(posedge clk) disable iff (rst)
    (advance && !known_func && !out_valid) |=> !out_valid)
    else $error("report produced for an unknown function");

  // Nothing is presented right after reset.
  a_reset_empty: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> (!out_valid && !in_valid))
    else $error("registers not empty after reset");
`endif

endmodule

// ===== tb/sv/tb_hid_key_report_builder_core.sv =====
`timescale 1ns / 1ps

module tb_hid_key_report_builder_core;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_EVENTS = 500;

  // Function codes the block does not know; requests with them are dropped.
  localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

  localparam logic [7:0] MOD_CODE_BASE = 8'd128;

  // Character to usage; bit 7 of an entry means left shift is held as well.
  localparam logic [7:0] CHAR_USAGE [128] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h28, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
    8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
    8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
    8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
    8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
    8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
    8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
    8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
    8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
    8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
    8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
    8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
  };

  typedef struct packed {
    hkrb_pkg::status_t                     status;
    logic                                  kind;
    logic [7:0]                            modifier;
    logic [hkrb_pkg::SHOWN_SLOTS-1:0][7:0] slots;
    logic [15:0]                           media;
  } key_report_t;

  logic clk;
  logic rst;

  hkrb_in_if  events ();
  hkrb_out_if reports ();

  hid_key_report_builder_core u_top (
    .clk     (clk),
    .rst     (rst),
    .events  (events),
    .reports (reports)
  );

  // Mirror of the report state kept by the block.
  logic [7:0]  mod_state;
  logic [7:0]  slot_state [hkrb_pkg::KEY_SLOT_COUNT];
  logic [15:0] media_state;

  key_report_t pending_reports [$];
  int          error_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one event to the mirrored state and returns the report it causes.
  function automatic key_report_t apply_event(logic [2:0] fn, logic [7:0] code,
                                              logic [15:0] bits);
    key_report_t rep;
    logic [7:0]  usage;
    logic        mapped;
    logic        present;
    logic        stored;
    rep.status = hkrb_pkg::ST_SENT;
    rep.kind = hkrb_pkg::KIND_KEYBOARD;
    case (fn)
      hkrb_pkg::FUNC_KEY_PRESS, hkrb_pkg::FUNC_KEY_RELEASE: begin
        mapped = 1'b1;
        usage = 8'h00;
        if (code >= hkrb_pkg::CODE_RAW_BASE) begin
          usage = code - hkrb_pkg::CODE_RAW_BASE;
        end else if (code[7]) begin
          mod_state[code[2:0]] = (fn == hkrb_pkg::FUNC_KEY_PRESS);
        end else begin
          usage = CHAR_USAGE[code[6:0]];
          if (usage == 8'h00) begin
            mapped = 1'b0;
          end else if ((usage & hkrb_pkg::USAGE_SHIFT_FLAG) != 8'h00) begin
            if (fn == hkrb_pkg::FUNC_KEY_PRESS) mod_state = mod_state | hkrb_pkg::LEFT_SHIFT_BIT;
            else mod_state = mod_state & ~hkrb_pkg::LEFT_SHIFT_BIT;
            usage = usage & hkrb_pkg::USAGE_MASK;
          end
        end
        if (fn == hkrb_pkg::FUNC_KEY_PRESS) begin
          if (!mapped) begin
            rep.status = hkrb_pkg::ST_WRITE_ERR;
          end else begin
            present = 1'b0;
            for (int i = 0; i < hkrb_pkg::KEY_SLOT_COUNT; i++)
              if (slot_state[i] == usage) present = 1'b1;
            // A usage of zero counts as present whenever some slot is empty.
            if (!present) begin
              stored = 1'b0;
              for (int i = 0; i < hkrb_pkg::KEY_SLOT_COUNT; i++) begin
                if (!stored && slot_state[i] == 8'h00) begin
                  slot_state[i] = usage;
                  stored = 1'b1;
                end
              end
              if (!stored) rep.status = hkrb_pkg::ST_WRITE_ERR;
            end
          end
        end else begin
          if (!mapped) begin
            rep.status = hkrb_pkg::ST_UNMAPPED;
          end else if (usage != 8'h00) begin
            for (int i = 0; i < hkrb_pkg::KEY_SLOT_COUNT; i++)
              if (slot_state[i] == usage) slot_state[i] = 8'h00;
          end
        end
      end
      hkrb_pkg::FUNC_MEDIA_PRESS: begin
        media_state = media_state | bits;
        rep.kind = hkrb_pkg::KIND_MEDIA;
      end
      hkrb_pkg::FUNC_MEDIA_REL: begin
        media_state = media_state & ~bits;
        rep.kind = hkrb_pkg::KIND_MEDIA;
      end
      default: begin
        for (int i = 0; i < hkrb_pkg::KEY_SLOT_COUNT; i++) slot_state[i] = 8'h00;
        mod_state = 8'h00;
        media_state = 16'h0000;
      end
    endcase
    rep.modifier = mod_state;
    for (int i = 0; i < hkrb_pkg::SHOWN_SLOTS; i++) begin
      if (i < hkrb_pkg::KEY_SLOT_COUNT) rep.slots[i] = slot_state[i];
      else rep.slots[i] = 8'h00;
    end
    rep.media = media_state;
    return rep;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Every accepted request with a known function code yields one report.
  always @(posedge clk) begin
    if (!rst && events.valid && events.ready &&
        events.func <= hkrb_pkg::FUNC_RELEASE_ALL)
      pending_reports.push_back(apply_event(events.func, events.key_code,
                                            events.media_bits));
  end

  always @(posedge clk) begin
    key_report_t                           want;
    logic [hkrb_pkg::SHOWN_SLOTS-1:0][7:0] got_slots;
    if (!rst && reports.valid && reports.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: report with none expected, expected none actual %h",
                 $time, reports.status);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        got_slots = {reports.slot_five, reports.slot_four, reports.slot_three,
                     reports.slot_two, reports.slot_one, reports.slot_zero};
        check_field("status", want.status, reports.status);
        check_field("report_kind", want.kind, reports.report_kind);
        check_field("modifier_bits", want.modifier, reports.modifier_bits);
        for (int i = 0; i < hkrb_pkg::SHOWN_SLOTS; i++)
          check_field($sformatf("slot %0d", i), want.slots[i], got_slots[i]);
        check_field("media_report", want.media, reports.media_report);
      end
    end
  end

  always @(posedge clk) begin
    reports.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_event(logic [2:0] fn, logic [7:0] code, logic [15:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      events.valid <= 1'b0;
      @(posedge clk);
    end
    events.valid      <= 1'b1;
    events.func       <= fn;
    events.key_code   <= code;
    events.media_bits <= bits;
    do @(posedge clk); while (events.ready !== 1'b1);
  endtask

  task automatic test_key_mapping();
    send_event(hkrb_pkg::FUNC_KEY_PRESS, "A", 16'h0000);
    send_event(hkrb_pkg::FUNC_KEY_PRESS, "a", 16'h0000);   // same usage, not stored twice
    send_event(hkrb_pkg::FUNC_KEY_PRESS, 8'd255, 16'hffff);
    send_event(hkrb_pkg::FUNC_KEY_PRESS, hkrb_pkg::CODE_RAW_BASE, 16'h0000);
    send_event(hkrb_pkg::FUNC_KEY_PRESS, 8'h00, 16'h0000);  // unmapped press
    send_event(hkrb_pkg::FUNC_KEY_PRESS, 8'h7f, 16'h0000);
    send_event(hkrb_pkg::FUNC_KEY_RELEASE, 8'h00, 16'h0000);  // unmapped release
    send_event(hkrb_pkg::FUNC_KEY_RELEASE, hkrb_pkg::CODE_RAW_BASE, 16'h0000);
  endtask

  task automatic test_modifiers();
    send_event(hkrb_pkg::FUNC_KEY_PRESS, MOD_CODE_BASE, 16'h0000);
    send_event(hkrb_pkg::FUNC_KEY_PRESS, MOD_CODE_BASE + 8'd7, 16'h0000);
    send_event(hkrb_pkg::FUNC_KEY_RELEASE, MOD_CODE_BASE, 16'h0000);
  endtask

  task automatic test_slot_overflow();
    send_event(hkrb_pkg::FUNC_KEY_PRESS, hkrb_pkg::CODE_RAW_BASE + 8'd1, 16'h0000);
    send_event(hkrb_pkg::FUNC_KEY_PRESS, hkrb_pkg::CODE_RAW_BASE + 8'd2, 16'h0000);
    send_event(hkrb_pkg::FUNC_KEY_PRESS, hkrb_pkg::CODE_RAW_BASE + 8'd3, 16'h0000);
    send_event(hkrb_pkg::FUNC_KEY_PRESS, hkrb_pkg::CODE_RAW_BASE + 8'd5, 16'h0000);
    send_event(hkrb_pkg::FUNC_KEY_PRESS, hkrb_pkg::CODE_RAW_BASE + 8'd6, 16'h0000);
    // With every slot taken, modifier and shift bits still get set.
    send_event(hkrb_pkg::FUNC_KEY_PRESS, MOD_CODE_BASE + 8'd2, 16'h0000);
    send_event(hkrb_pkg::FUNC_KEY_PRESS, "!", 16'h0000);
  endtask

  task automatic test_key_release();
    send_event(hkrb_pkg::FUNC_KEY_RELEASE, "A", 16'h0000);
    send_event(hkrb_pkg::FUNC_KEY_RELEASE, hkrb_pkg::CODE_RAW_BASE + 8'd1, 16'h0000);
  endtask

  task automatic test_media();
    send_event(hkrb_pkg::FUNC_MEDIA_PRESS, 8'h00, 16'hffff);
    send_event(hkrb_pkg::FUNC_MEDIA_REL, 8'hff, 16'h8001);
    send_event(hkrb_pkg::FUNC_MEDIA_PRESS, 8'h00, 16'h0000);
  endtask

  task automatic test_unknown_func();
    send_event(FUNC_UNUSED_LO, "a", 16'h1234);
    send_event(FUNC_UNUSED_HI, 8'hff, 16'hffff);
  endtask

  task automatic test_release_all();
    send_event(hkrb_pkg::FUNC_RELEASE_ALL, 8'h00, 16'h0000);
  endtask

  function automatic logic [7:0] pick_key_code();
    int r;
    r = $urandom_range(99);
    // A small pool of usages makes repeats, full slots and matching releases common.
    if (r < 35) return hkrb_pkg::CODE_RAW_BASE + 8'($urandom_range(9));
    if (r < 55) return MOD_CODE_BASE + 8'($urandom_range(7));
    if (r < 80) return 8'($urandom_range(8'h7e, 8'h20));
    if (r < 90) return 8'($urandom_range(127));
    return 8'($urandom_range(255));
  endfunction

  task automatic test_random_traffic(int send_pct, int recv_pct);
    int          sent;
    int          r;
    logic [15:0] bits;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < RANDOM_EVENTS) begin
      r = $urandom_range(99);
      if ($urandom_range(3) == 0) bits = 16'h0001 << $urandom_range(15);
      else bits = 16'($urandom_range(16'hffff));
      if (r < 35) begin
        send_event(hkrb_pkg::FUNC_KEY_PRESS, pick_key_code(), bits);
      end else if (r < 65) begin
        send_event(hkrb_pkg::FUNC_KEY_RELEASE, pick_key_code(), bits);
      end else if (r < 76) begin
        send_event(hkrb_pkg::FUNC_MEDIA_PRESS, pick_key_code(), bits);
      end else if (r < 87) begin
        send_event(hkrb_pkg::FUNC_MEDIA_REL, pick_key_code(), bits);
      end else if (r < 90) begin
        send_event(hkrb_pkg::FUNC_RELEASE_ALL, pick_key_code(), bits);
      end else if (r < 93) begin
        send_event(3'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO)), pick_key_code(), bits);
        continue;
      end else begin
        send_event(hkrb_pkg::FUNC_KEY_PRESS, pick_key_code(), bits);
      end
      sent++;
    end
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 11;
    recv_idle_pct = 72;
    mod_state = 8'h00;
    media_state = 16'h0000;
    for (int i = 0; i < hkrb_pkg::KEY_SLOT_COUNT; i++) slot_state[i] = 8'h00;
    rst = 1'b1;
    events.valid = 1'b0;
    events.func = hkrb_pkg::FUNC_KEY_PRESS;
    events.key_code = 8'h00;
    events.media_bits = 16'h0000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_key_mapping();
    test_modifiers();
    test_slot_overflow();
    test_key_release();
    test_media();
    test_unknown_func();
    test_release_all();
    test_random_traffic(11, 72);
    test_random_traffic(72, 11);
    test_random_traffic(0, 0);

    events.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/hkrb_pkg.sv
sv/hkrb_in_if.sv
sv/hkrb_out_if.sv
sv/hid_key_report_builder_core.sv
tb/sv/tb_hid_key_report_builder_core.sv
